FILE: src/atomic_memory_op_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the atomic memory-operation unit
// Clocked, reset-qualified immediate and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_MEMORY_OP_UNIT_ASSERT_SVH
`define ATOMIC_MEMORY_OP_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define AMO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define AMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/amo_pkg.sv
// ----------------------------------------------------------------------------
// amo_pkg
// Types and constants shared by the atomic memory-operation unit.
// ----------------------------------------------------------------------------
package amo_pkg;

  localparam int unsigned ModeW   = 4;
  localparam int unsigned SizeW   = 2;
  localparam int unsigned AddrW   = 13;
  localparam int unsigned DataW   = 64;
  localparam int unsigned DwIdxW  = AddrW - 3;
  localparam int unsigned ReqW    = ModeW + SizeW + AddrW + 2 * DataW;
  localparam int unsigned RspW    = DataW + 2;
  localparam int unsigned InBusW  = ((ReqW + 7) / 8) * 8;
  localparam int unsigned OutBusW = ((RspW + 7) / 8) * 8;

  // Lane masks for each access size
  localparam logic [DataW-1:0] MaskByte = 64'h0000_0000_0000_00FF;
  localparam logic [DataW-1:0] MaskHalf = 64'h0000_0000_0000_FFFF;
  localparam logic [DataW-1:0] MaskWord = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DataW-1:0] MaskDbl  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD  = 4'd0,
    MODE_STORE = 4'd1,
    MODE_ADD   = 4'd2,
    MODE_SUB   = 4'd3,
    MODE_AND   = 4'd4,
    MODE_OR    = 4'd5,
    MODE_XOR   = 4'd6,
    MODE_XCHG  = 4'd7,
    MODE_CAS   = 4'd8
  } amo_mode_e;

  typedef enum logic [SizeW-1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_DBL  = 2'd3
  } amo_size_e;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } amo_state_e;

  // Request word, last field in the lowest bits
  typedef struct packed {
    logic [DataW-1:0] expected_value;
    logic [DataW-1:0] operand_value;
    logic [AddrW-1:0] byte_address;
    logic [SizeW-1:0] size_code;
    logic [ModeW-1:0] mode;
  } amo_req_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic             misaligned;
    logic             swap_done;
    logic [DataW-1:0] old_value;
  } amo_rsp_t;

  function automatic logic [DataW-1:0] lane_mask(input logic [SizeW-1:0] sc);
    logic [DataW-1:0] m;
    case (amo_size_e'(sc))
      SIZE_BYTE: m = MaskByte;
      SIZE_HALF: m = MaskHalf;
      SIZE_WORD: m = MaskWord;
      SIZE_DBL:  m = MaskDbl;
      default:   m = MaskDbl;
    endcase
    return m;
  endfunction

endpackage

FILE: src/amo_ram.sv
// ----------------------------------------------------------------------------
// amo_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module amo_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/amo_alu.sv
// ----------------------------------------------------------------------------
// amo_alu
// Lane extract, operation and merge for one read-modify-write.
// ----------------------------------------------------------------------------
module amo_alu (
  input  amo_pkg::amo_req_t         req_i,
  input  logic [amo_pkg::DataW-1:0] word_i,
  output logic                      we_o,
  output logic [amo_pkg::DataW-1:0] wdata_o,
  output amo_pkg::amo_rsp_t         rsp_o
);

  import amo_pkg::*;

  logic [2:0]       offset;
  logic [3:0]       bytes;
  logic             misaligned;
  logic [DataW-1:0] mask;
  logic [3:0]       shift_full;
  logic [5:0]       shift;
  logic [DataW-1:0] opnd;
  logic [DataW-1:0] expv;
  logic [DataW-1:0] oldv;
  logic [DataW-1:0] newv;
  logic             write;
  logic             done;

  assign offset = req_i.byte_address[2:0];
  assign mask   = lane_mask(req_i.size_code);
  assign opnd   = req_i.operand_value & mask;
  assign expv   = req_i.expected_value & mask;

  // Size in bytes and alignment check
  always_comb begin
    case (amo_size_e'(req_i.size_code))
      SIZE_BYTE: begin
        bytes      = 4'd1;
        misaligned = 1'b0;
      end
      SIZE_HALF: begin
        bytes      = 4'd2;
        misaligned = offset[0];
      end
      SIZE_WORD: begin
        bytes      = 4'd4;
        misaligned = |offset[1:0];
      end
      SIZE_DBL: begin
        bytes      = 4'd8;
        misaligned = |offset;
      end
      default: begin
        bytes      = 4'd8;
        misaligned = |offset;
      end
    endcase
  end

  // Big-endian lane: byte 0 is the top byte of the doubleword
  assign shift_full = 4'd8 - bytes - {1'b0, offset};
  assign shift      = {shift_full[2:0], 3'b000};
  assign oldv       = (word_i >> shift) & mask;

  // Apply the operation to the old lane
  always_comb begin
    write = 1'b1;
    done  = 1'b1;
    newv  = oldv;
    case (amo_mode_e'(req_i.mode))
      MODE_STORE: newv = opnd;
      MODE_ADD:   newv = oldv + opnd;
      MODE_SUB:   newv = oldv - opnd;
      MODE_AND:   newv = oldv & opnd;
      MODE_OR:    newv = oldv | opnd;
      MODE_XOR:   newv = oldv ^ opnd;
      MODE_XCHG:  newv = opnd;
      MODE_CAS: begin
        done  = (oldv == expv);
        write = done;
        newv  = opnd;
      end
      default: begin
        write = 1'b0;
        newv  = oldv;
      end
    endcase
  end

  // Merge the new lane back, other bytes untouched
  assign wdata_o = (word_i & ~(mask << shift)) | ((newv & mask) << shift);
  assign we_o    = write && !misaligned;

  // Misaligned requests report zero and no swap
  assign rsp_o.old_value  = misaligned ? '0 : oldv;
  assign rsp_o.swap_done  = misaligned ? 1'b0 : done;
  assign rsp_o.misaligned = misaligned;

endmodule

FILE: src/atomic_memory_op_unit.sv
// ----------------------------------------------------------------------------
// atomic_memory_op_unit
// Atomic read-modify-write operations on a store of 64-bit doublewords.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents (lowest bits first)
//  s_axis   in   mode[4] size_code[2] byte_address[13] operand[64] expected[64]
//  m_axis   out  old_value[64] swap_done[1] misaligned[1]
//
//  A request is accepted in ST_IDLE, which issues the registered memory read;
//  ST_MODIFY then modifies the lane, writes the doubleword back and loads the
//  output register. The single memory port pair and its registered read set this.
//  Reset clears control only; the store contents are undefined until written.
//  A finished result waits in the output register; a new request is taken
//  when the unit is idle and the output register is empty or draining.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // mode, size_code, byte_address, operand_value, expected_value, zero pad
  input  logic [amo_pkg::InBusW-1:0]  s_axis_tdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // old_value, swap_done, misaligned, zero pad
  output logic [amo_pkg::OutBusW-1:0] m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready
);

  import amo_pkg::*;

  localparam int unsigned IdxW = $clog2(STORE_DEPTH);

  amo_state_e       state_q, state_d;
  amo_req_t         in_req;
  amo_req_t         req_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  in_idx;
  logic             s_accept;
  logic             out_valid_q, out_valid_d;
  amo_rsp_t         out_rsp_q;
  amo_rsp_t         alu_rsp;
  logic             alu_we;
  logic [DataW-1:0] alu_wdata;
  logic [DataW-1:0] ram_rdata;
  logic             ram_we;

  assign in_req   = amo_req_t'(s_axis_tdata[ReqW-1:0]);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Doubleword index modulo the store depth: split into two 5-bit halves,
  // look up each half's residue and fold with one compare and subtract.
  logic [DwIdxW-1:0] dw_idx;
  logic [IdxW-1:0]   hi_tbl [32];
  logic [IdxW-1:0]   lo_tbl [32];
  logic [IdxW:0]     idx_sum;

  for (genvar g = 0; g < 32; g++) begin : g_mod_tbl
    assign hi_tbl[g] = IdxW'((g * 32) % STORE_DEPTH);
    assign lo_tbl[g] = IdxW'(g % STORE_DEPTH);
  end

  assign dw_idx  = in_req.byte_address[AddrW-1:3];
  assign idx_sum = {1'b0, hi_tbl[dw_idx[9:5]]} + {1'b0, lo_tbl[dw_idx[4:0]]};
  assign in_idx  = (idx_sum >= (IdxW+1)'(STORE_DEPTH))
                 ? IdxW'(idx_sum - (IdxW+1)'(STORE_DEPTH))
                 : idx_sum[IdxW-1:0];

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and input ready
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the accepted request for the modify cycle
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_q <= in_req;
      idx_q <= in_idx;
    end
  end

  amo_ram #(
    .Width(DataW),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(alu_wdata),
    .re_i   (s_accept),
    .raddr_i(in_idx),
    .rdata_o(ram_rdata)
  );

  amo_alu u_alu (
    .req_i  (req_q),
    .word_i (ram_rdata),
    .we_o   (alu_we),
    .wdata_o(alu_wdata),
    .rsp_o  (alu_rsp)
  );

  assign ram_we = (state_q == ST_MODIFY) && alu_we;

  // Output register: load at the end of the modify cycle, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_MODIFY) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MODIFY) begin
      out_rsp_q <= alu_rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutBusW-RspW){1'b0}}, out_rsp_q};

  `include "atomic_memory_op_unit_assert.svh"

  `AMO_ASSERT_NOW(a_no_accept_busy, clk_i, rst_ni, state_q == ST_MODIFY, !s_accept, "request accepted during modify")
  `AMO_ASSERT_NOW(a_write_in_modify, clk_i, rst_ni, ram_we, state_q == ST_MODIFY, "store written outside modify")
  `AMO_ASSERT_NEXT(a_accept_modify, clk_i, rst_ni, s_accept, state_q == ST_MODIFY, "accept not followed by modify")
  `AMO_ASSERT_NEXT(a_modify_result, clk_i, rst_ni, state_q == ST_MODIFY, out_valid_q, "modify produced no result")
  `AMO_ASSERT_NOW(a_out_free_modify, clk_i, rst_ni, state_q == ST_MODIFY, !out_valid_q, "result overwrites a pending word")
  `AMO_ASSERT_NOW(a_misaligned_clean, clk_i, rst_ni, out_valid_q && out_rsp_q.misaligned, !out_rsp_q.swap_done && out_rsp_q.old_value == '0, "misaligned result not cleared")

endmodule
